// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL files.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UCPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define UCPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/core/ucpe_pkg.sv -----
package ucpe_pkg;

  // Component tags carried with each input byte.
  localparam logic [2:0] COMP_HOST     = 3'd0;
  localparam logic [2:0] COMP_PATH     = 3'd1;
  localparam logic [2:0] COMP_QUERY    = 3'd2;
  localparam logic [2:0] COMP_FRAGMENT = 3'd3;
  localparam logic [2:0] COMP_SCHEME   = 3'd4;

  // The escape introducer.
  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] component;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Encoded form of one input item, ready for serialization.
  typedef struct packed {
    logic       escape;
    logic [7:0] lit_byte;
    logic [7:0] hi_hex;
    logic [7:0] lo_hex;
  } enc_t;

endpackage

// ----- rtl/core/ucpe_classify.sv -----
module ucpe_classify (
  input  ucpe_pkg::in_item_t item,
  output ucpe_pkg::enc_t     enc
);

  // Upper-case hex digit of one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h37 + {4'h0, nib};
    end
    return d;
  endfunction

  // Characters allowed in every component.
  function automatic logic in_base_set(input logic [7:0] b);
    logic ok;
    ok = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
         ((b >= 8'h30) && (b <= 8'h39));
    unique case (b)
      8'h21, 8'h24, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
      8'h2D, 8'h2E, 8'h3A, 8'h3B, 8'h3D, 8'h5F, 8'h7E: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  logic [7:0] low_byte;
  logic       is_upper;
  logic       fold;
  logic       base_ok;
  logic       allowed;

  // Host and scheme bytes are lowercased first, letters only.
  assign is_upper = (item.data_byte >= 8'h41) && (item.data_byte <= 8'h5A);
  assign fold     = is_upper && ((item.component == ucpe_pkg::COMP_HOST) ||
                                 (item.component == ucpe_pkg::COMP_SCHEME));
  assign low_byte = fold ? (item.data_byte + 8'h20) : item.data_byte;
  assign base_ok  = in_base_set(low_byte);

  // Per-component allowed set; scheme always passes, unused tags never do.
  always_comb begin
    unique case (item.component)
      ucpe_pkg::COMP_HOST:
        allowed = base_ok || (low_byte == 8'h26) || (low_byte == 8'h5B) ||
                  (low_byte == 8'h5D);
      ucpe_pkg::COMP_PATH:
        allowed = base_ok || (low_byte == 8'h26) || (low_byte == 8'h40);
      ucpe_pkg::COMP_QUERY:
        allowed = base_ok || (low_byte == 8'h2F) || (low_byte == 8'h3F) ||
                  (low_byte == 8'h40);
      ucpe_pkg::COMP_FRAGMENT:
        allowed = base_ok || (low_byte == 8'h26) || (low_byte == 8'h2F) ||
                  (low_byte == 8'h3F) || (low_byte == 8'h40);
      ucpe_pkg::COMP_SCHEME:
        allowed = 1'b1;
      default:
        allowed = 1'b0;
    endcase
  end

  // Build the encoded item.
  assign enc.escape   = !allowed;
  assign enc.lit_byte = low_byte;
  assign enc.hi_hex   = hex_digit(low_byte[7:4]);
  assign enc.lo_hex   = hex_digit(low_byte[3:0]);

endmodule

// ----- rtl/core/ucpe_emit.sv -----
module ucpe_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ucpe_pkg::enc_t       enc,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ucpe_pkg::out_item_t  out_data
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_HI,
    PH_LO
  } phase_t;

  logic           em_v_r;
  phase_t         phase_r;
  ucpe_pkg::enc_t enc_r;
  logic           is_last;
  logic           fire;

  // Current result byte from the held item and the phase.
  always_comb begin
    out_data.out_byte = enc_r.lit_byte;
    is_last           = 1'b1;
    if (enc_r.escape) begin
      unique case (phase_r)
        PH_FIRST: begin
          out_data.out_byte = ucpe_pkg::CHAR_PERCENT;
          is_last           = 1'b0;
        end
        PH_HI: begin
          out_data.out_byte = enc_r.hi_hex;
          is_last           = 1'b0;
        end
        PH_LO: begin
          out_data.out_byte = enc_r.lo_hex;
          is_last           = 1'b1;
        end
        default: begin
          out_data.out_byte = enc_r.lo_hex;
          is_last           = 1'b1;
        end
      endcase
    end
    out_data.last_of_run = is_last;
  end

  assign out_valid            = em_v_r;
  assign fire                 = em_v_r && !out_stall;
  assign free                 = !em_v_r || (fire && is_last);

  // Hold one encoded item and step through its result bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r  <= 1'b0;
      phase_r <= PH_FIRST;
    end else if (load) begin
      em_v_r  <= 1'b1;
      phase_r <= PH_FIRST;
      enc_r   <= enc;
    end else if (fire) begin
      if (is_last) begin
        em_v_r  <= 1'b0;
        phase_r <= PH_FIRST;
      end else if (phase_r == PH_FIRST) begin
        phase_r <= PH_HI;
      end else begin
        phase_r <= PH_LO;
      end
    end
  end

endmodule

// ----- rtl/core/uri_component_percent_encoder_unit.sv -----
// URI component percent encoder. Each item is one byte tagged with its URI
// component; it yields one result byte when it passes literally and three
// ('%' and two upper-case hex digits) when it is escaped. The output port
// carries one byte per cycle while out_stall is low, so an escaped item holds
// the output longer than a literal one; the serializer sets the rate.
// A new item may be accepted every cycle while items pass literally and the
// output is not stalled. Each item passes through the input register and
// then the serializer register before its first result byte appears.
`include "assert_macros.svh"

module uri_component_percent_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ucpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ucpe_pkg::out_item_t out_data
);

  logic               in_v_r;
  ucpe_pkg::in_item_t in_item_r;
  ucpe_pkg::enc_t     enc;
  logic               em_free;
  logic               load_em;
  logic               in_fire;

  // The input register hands over whenever the serializer frees up.
  assign load_em  = in_v_r && em_free;
  assign in_stall = in_v_r && !em_free;
  assign in_fire  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r    <= 1'b1;
      in_item_r <= in_data;
    end else if (load_em) begin
      in_v_r <= 1'b0;
    end
  end

  // Classification and hex conversion.
  ucpe_classify u_classify (
    .item (in_item_r),
    .enc  (enc)
  );

  // Result serializer.
  ucpe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_em),
    .enc       (enc),
    .free      (em_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Stall is raised only while an item waits in the input register.
  `UCPE_ASSERT_IMP(a_stall_needs_item, in_stall, in_v_r)
  // An escape sequence never breaks off after a non-final byte.
  `UCPE_ASSERT_NXT(a_escape_continues, out_valid && !out_stall && !out_data.last_of_run,
                   out_valid)
  // Taking a new item over a held one moves the held one on in the same cycle.
  `UCPE_ASSERT_IMP(a_no_overwrite, in_fire && in_v_r, load_em)

endmodule
